// ----- hw/rtl/heightfield_gather4_sampler_macros.svh -----
// heightfield_gather4_sampler_macros.svh
// assertion macros used by hg4s_checker, no other dependencies
`ifndef HEIGHTFIELD_GATHER4_SAMPLER_MACROS_SVH
`define HEIGHTFIELD_GATHER4_SAMPLER_MACROS_SVH

// rule checked in the cycle after the trigger, also through reset
`define HG4S_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("hg4s check failed: next-cycle rule");

// rule checked after the delay d given to the macro, dropped by reset
`define HG4S_ASSERT_DELAY(lbl, a, d, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##(d) (c)) \
    else $error("hg4s check failed: delayed rule");

`endif

// ----- hw/rtl/hg4s_pkg.sv -----
// hg4s_pkg: constants, types and helpers of the heightfield gather sampler
// no dependencies
package hg4s_pkg;

  localparam int MAX_COLS    = 256;
  localparam int MAX_ROWS    = 256;
  localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int TEXEL_W = 32;
  localparam int COORD_W = 24;
  localparam int FRAC_W  = 16;
  localparam int SIZE_W  = 9;
  localparam int POS_W   = 8;

  localparam int PROD_W = COORD_W + SIZE_W + 1;
  localparam int IDX_W  = PROD_W - FRAC_W;
  localparam logic signed [PROD_W-1:0] HALF_Q = PROD_W'(1) <<< (FRAC_W - 1);

  // remainder pipeline
  localparam int MOD_W      = SIZE_W + IDX_W - 1;
  localparam int MOD_STAGES = 4;
  localparam int MOD_STEP   = (MOD_W + MOD_STAGES - 1) / MOD_STAGES;
  localparam int MOD_PAD    = MOD_STEP * MOD_STAGES;

  localparam int AXIS_LAT   = MOD_STAGES + 3;
  localparam int RESULT_LAT = AXIS_LAT + 2;

  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_GATHER  = 1'b1;
  localparam logic MODE_CLAMP  = 1'b0;
  localparam logic MODE_REPEAT = 1'b1;

  localparam int PADDR_W   = 4;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_FIELD_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FIELD_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ADDRESS_MODE = 2'd2;

  localparam int NUM_BANKS = 4;

  typedef logic [SIZE_W-1:0] size_t;

  typedef struct packed {
    size_t n;
    logic  wrap;
  } axis_cfg_t;

  typedef struct packed {
    size_t lo;
    size_t hi;
  } axis_pair_t;

  typedef struct packed {
    logic               action;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic [TEXEL_W-1:0] value;
  } op_t;

  function automatic size_t eff_size(size_t v, int maxv);
    size_t s;
    if (v == '0) begin
      s = SIZE_W'(1);
    end else if (int'(v) > maxv) begin
      s = SIZE_W'(maxv);
    end else begin
      s = v;
    end
    return s;
  endfunction

endpackage

// ----- hw/rtl/hg4s_ram.sv -----
// hg4s_ram: generic single-port ram with registered read
// no dependencies
module hg4s_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/hg4s_mod.sv -----
// hg4s_mod: pipelined restoring remainder of a non-negative value by the field size
// depends on hg4s_pkg
module hg4s_mod (
  input  logic                        clk,
  input  logic [hg4s_pkg::MOD_W-1:0]  q_in,
  input  hg4s_pkg::size_t             n,
  output hg4s_pkg::size_t             rem
);
  import hg4s_pkg::*;

  logic [MOD_PAD-1:0] q_r [MOD_STAGES-1];
  size_t              r_r [MOD_STAGES];

  for (genvar s = 0; s < MOD_STAGES; s++) begin : g_stage
    localparam int HI = MOD_PAD - 1 - s * MOD_STEP;
    logic [MOD_PAD-1:0] q_cur;
    size_t              r_cur;
    size_t              r_nxt;
    logic [SIZE_W:0]    step_t;

    if (s == 0) begin : g_first
      assign q_cur = MOD_PAD'(q_in);
      assign r_cur = '0;
    end else begin : g_next
      assign q_cur = q_r[s-1];
      assign r_cur = r_r[s-1];
    end

    always_comb begin
      r_nxt  = r_cur;
      step_t = '0;
      for (int k = 0; k < MOD_STEP; k++) begin
        step_t = {r_nxt, q_cur[HI-k]};
        if (step_t >= {1'b0, n}) begin
          step_t = step_t - {1'b0, n};
        end
        r_nxt = step_t[SIZE_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      r_r[s] <= r_nxt;
    end

    if (s < MOD_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        q_r[s] <= q_cur;
      end
    end
  end

  assign rem = r_r[MOD_STAGES-1];

endmodule

// ----- hw/rtl/hg4s_axis.sv -----
// hg4s_axis: base index and addressed neighbour pair for one axis
// depends on hg4s_pkg and hg4s_mod
module hg4s_axis (
  input  logic                                 clk,
  input  logic signed [hg4s_pkg::COORD_W-1:0]  coord,
  input  hg4s_pkg::axis_cfg_t                  cfg,
  output hg4s_pkg::axis_pair_t                 pair
);
  import hg4s_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  logic signed [PROD_W-1:0] shift_t;
  logic [IDX_W-1:0]         p_nxt, p_r;
  logic [IDX_W-1:0]         p1;
  logic [MOD_W-1:0]         q_in;
  size_t                    rem;
  logic [SIZE_W:0]          rem_inc;
  axis_pair_t               clamp_nxt;
  axis_pair_t               clamp_r [MOD_STAGES];
  axis_pair_t               pair_nxt, pair_r;
  logic signed [SIZE_W:0]   n_s;

  function automatic size_t clamp_pos(logic [IDX_W-1:0] p, size_t n);
    size_t c;
    if (p[IDX_W-1]) begin
      c = '0;
    end else if (p >= IDX_W'(n)) begin
      c = n - SIZE_W'(1);
    end else begin
      c = p[SIZE_W-1:0];
    end
    return c;
  endfunction

  assign n_s      = $signed({1'b0, cfg.n});
  assign prod_nxt = PROD_W'(coord) * PROD_W'(n_s);
  assign shift_t  = prod_r - HALF_Q;
  assign p_nxt    = shift_t[PROD_W-1:FRAC_W];
  assign p1       = p_r + IDX_W'(1);

  // offset by a multiple of the size so the remainder input is never negative
  assign q_in = {{(MOD_W-IDX_W){p_r[IDX_W-1]}}, p_r} + (MOD_W'(cfg.n) << (IDX_W - 1));

  assign clamp_nxt.lo = clamp_pos(p_r, cfg.n);
  assign clamp_nxt.hi = clamp_pos(p1, cfg.n);

  hg4s_mod u_mod (
    .clk  (clk),
    .q_in (q_in),
    .n    (cfg.n),
    .rem  (rem)
  );

  assign rem_inc = {1'b0, rem} + (SIZE_W+1)'(1);

  always_comb begin
    if (cfg.wrap == MODE_REPEAT) begin
      pair_nxt.lo = rem;
      pair_nxt.hi = (rem_inc == {1'b0, cfg.n}) ? '0 : rem_inc[SIZE_W-1:0];
    end else begin
      pair_nxt = clamp_r[MOD_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    p_r        <= p_nxt;
    clamp_r[0] <= clamp_nxt;
    for (int k = 1; k < MOD_STAGES; k++) begin
      clamp_r[k] <= clamp_r[k-1];
    end
    pair_r <= pair_nxt;
  end

  assign pair = pair_r;

endmodule

// ----- hw/rtl/heightfield_gather4_sampler.sv -----
// heightfield_gather4_sampler: top level, config registers, item pipeline and texel banks
// depends on hg4s_pkg, hg4s_axis and hg4s_ram
//
// channel   handshake               payload
// in        start / busy            in_action, in_write_*, in_coord_u, in_coord_v
// out       out_valid (strobe)      out_texel_low_left_up .. out_texel_base
// cfg       psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// one item is taken every cycle while busy is low; a gather result strobes once its accept has passed
// the input registers, the multiply, floor and 4-stage remainder pipeline, the pair register and the ram read
// the four banks are full copies of the store, one per gather position, written together
// reset is synchronous; busy is high only in the cycle after a reset edge, no clearing pass
// results cannot be stalled and need no back-pressure
module heightfield_gather4_sampler (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_action,
  input  logic [hg4s_pkg::POS_W-1:0]           in_write_col,
  input  logic [hg4s_pkg::POS_W-1:0]           in_write_row,
  input  logic [hg4s_pkg::TEXEL_W-1:0]         in_write_value,
  input  logic signed [hg4s_pkg::COORD_W-1:0]  in_coord_u,
  input  logic signed [hg4s_pkg::COORD_W-1:0]  in_coord_v,
  output logic                                 out_valid,
  output logic [hg4s_pkg::TEXEL_W-1:0]         out_texel_low_left_up,
  output logic [hg4s_pkg::TEXEL_W-1:0]         out_texel_right_up,
  output logic [hg4s_pkg::TEXEL_W-1:0]         out_texel_right_base,
  output logic [hg4s_pkg::TEXEL_W-1:0]         out_texel_base,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hg4s_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import hg4s_pkg::*;

  logic                       busy_r;
  logic                       accept;
  logic                       cfg_we;
  logic [REG_IDX_W-1:0]       reg_idx;
  size_t                      field_width_r, field_height_r;
  logic                       address_mode_r;
  axis_cfg_t                  cfg_u, cfg_v;
  axis_pair_t                 pair_x, pair_y;

  logic [AXIS_LAT:0]          vld_r;
  op_t                        op_r [AXIS_LAT+1];
  logic signed [COORD_W-1:0]  coord_u_r, coord_v_r;

  op_t                        op_l;
  logic                       in_range;
  logic                       bank_we;
  logic [ADDR_W-1:0]          waddr;
  logic [ADDR_W-1:0]          bank_addr [NUM_BANKS];
  logic [TEXEL_W-1:0]         bank_rdata [NUM_BANKS];
  logic                       out_valid_r;

  function automatic logic [ADDR_W-1:0] texel_addr(size_t y, size_t x);
    return ADDR_W'(y) * ADDR_W'(MAX_COLS) + ADDR_W'(x);
  endfunction

  // config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_width_r  <= SIZE_W'(256);
      field_height_r <= SIZE_W'(256);
      address_mode_r <= MODE_CLAMP;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_FIELD_WIDTH:  field_width_r  <= pwdata[SIZE_W-1:0];
        REG_FIELD_HEIGHT: field_height_r <= pwdata[SIZE_W-1:0];
        REG_ADDRESS_MODE: address_mode_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FIELD_WIDTH:  prdata = 32'(field_width_r);
      REG_FIELD_HEIGHT: prdata = 32'(field_height_r);
      REG_ADDRESS_MODE: prdata = 32'(address_mode_r);
      default:          prdata = '0;
    endcase
  end

  // input side
  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[AXIS_LAT-1:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    op_r[0]   <= '{action: in_action, col: in_write_col, row: in_write_row,
                   value: in_write_value};
    coord_u_r <= in_coord_u;
    coord_v_r <= in_coord_v;
    for (int k = 1; k <= AXIS_LAT; k++) begin
      op_r[k] <= op_r[k-1];
    end
  end

  // coordinate pipelines
  assign cfg_u = '{n: eff_size(field_width_r, MAX_COLS), wrap: address_mode_r};
  assign cfg_v = '{n: eff_size(field_height_r, MAX_ROWS), wrap: address_mode_r};

  hg4s_axis u_axis_u (
    .clk   (clk),
    .coord (coord_u_r),
    .cfg   (cfg_u),
    .pair  (pair_x)
  );

  hg4s_axis u_axis_v (
    .clk   (clk),
    .coord (coord_v_r),
    .cfg   (cfg_v),
    .pair  (pair_y)
  );

  // bank access, writes take the same path so order is kept
  assign op_l     = op_r[AXIS_LAT];
  assign in_range = (int'(op_l.col) < MAX_COLS) && (int'(op_l.row) < MAX_ROWS);
  assign bank_we  = vld_r[AXIS_LAT] && (op_l.action == ACT_WRITE) && in_range;
  assign waddr    = ADDR_W'(op_l.row) * ADDR_W'(MAX_COLS) + ADDR_W'(op_l.col);

  always_comb begin
    if (op_l.action == ACT_WRITE) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        bank_addr[b] = waddr;
      end
    end else begin
      bank_addr[0] = texel_addr(pair_y.hi, pair_x.lo);
      bank_addr[1] = texel_addr(pair_y.hi, pair_x.hi);
      bank_addr[2] = texel_addr(pair_y.lo, pair_x.hi);
      bank_addr[3] = texel_addr(pair_y.lo, pair_x.lo);
    end
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    hg4s_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (STORE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we),
      .addr  (bank_addr[b]),
      .wdata (op_l.value),
      .rdata (bank_rdata[b])
    );
  end

  // result side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[AXIS_LAT] && (op_l.action == ACT_GATHER);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_texel_low_left_up = bank_rdata[0];
  assign out_texel_right_up    = bank_rdata[1];
  assign out_texel_right_base  = bank_rdata[2];
  assign out_texel_base        = bank_rdata[3];

endmodule

// ----- hw/rtl/hg4s_checker.sv -----
// hg4s_checker: port-level checks of the heightfield gather sampler, bound to the top level
// depends on hg4s_pkg and heightfield_gather4_sampler_macros.svh
`include "heightfield_gather4_sampler_macros.svh"

module hg4s_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_action,
  input logic out_valid
);
  import hg4s_pkg::*;

  // reset flushes results and holds off items in the cycle after it
  `HG4S_ASSERT_NEXT(a_reset_quiet, !rst_n, busy && !out_valid)
  `HG4S_ASSERT_NEXT(a_ready_after_reset, rst_n, !busy)
  `HG4S_ASSERT_DELAY(a_gather_result, start && !busy && in_action == ACT_GATHER, RESULT_LAT, out_valid)
  `HG4S_ASSERT_DELAY(a_write_silent, start && !busy && in_action == ACT_WRITE, RESULT_LAT, !out_valid)

endmodule

bind heightfield_gather4_sampler hg4s_checker u_hg4s_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_action (in_action),
  .out_valid (out_valid)
);
